// ----- hw/rtl/iee_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, codes and the control store of the infix expression
// evaluator: character codes, status codes, control word layout, the
// microprogram and the character dispatch table.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int IEE_STACK_DEPTH = 16;
  localparam int IEE_DATA_WIDTH  = 32;
  localparam int IEE_VALUE_W     = 32;
  localparam int IEE_UPC_W       = 5;

  // characters
  localparam logic [7:0] IEE_CH_0     = 8'h30;
  localparam logic [7:0] IEE_CH_9     = 8'h39;
  localparam logic [7:0] IEE_CH_OPEN  = 8'h28;
  localparam logic [7:0] IEE_CH_CLOSE = 8'h29;
  localparam logic [7:0] IEE_CH_MUL   = 8'h2A;
  localparam logic [7:0] IEE_CH_DIV   = 8'h2F;
  localparam logic [7:0] IEE_CH_ADD   = 8'h2B;
  localparam logic [7:0] IEE_CH_SUB   = 8'h2D;

  // result status
  localparam logic [1:0] IEE_ST_OK       = 2'd0;
  localparam logic [1:0] IEE_ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] IEE_ST_NEST     = 2'd2;

  // pending operator of the current term
  localparam logic [1:0] IEE_MODE_NONE = 2'd0;
  localparam logic [1:0] IEE_MODE_MUL  = 2'd1;
  localparam logic [1:0] IEE_MODE_DIV  = 2'd2;

  // position inside a factor
  localparam logic [1:0] IEE_PH_START  = 2'd0;
  localparam logic [1:0] IEE_PH_NUMBER = 2'd1;
  localparam logic [1:0] IEE_PH_CLOSED = 2'd2;

  // datapath actions
  localparam logic [3:0] A_WAIT      = 4'd0;
  localparam logic [3:0] A_DIGIT     = 4'd1;
  localparam logic [3:0] A_PUSH      = 4'd2;
  localparam logic [3:0] A_OVF       = 4'd3;
  localparam logic [3:0] A_FACTOR    = 4'd4;
  localparam logic [3:0] A_DIVTAKE   = 4'd5;
  localparam logic [3:0] A_SUM       = 4'd6;
  localparam logic [3:0] A_TERM      = 4'd7;
  localparam logic [3:0] A_VALUE     = 4'd8;
  localparam logic [3:0] A_VALUE_FIN = 4'd9;
  localparam logic [3:0] A_POP       = 4'd10;
  localparam logic [3:0] A_EMIT      = 4'd11;

  // stall conditions
  localparam logic [1:0] S_NONE     = 2'd0;
  localparam logic [1:0] S_NO_ITEM  = 2'd1;
  localparam logic [1:0] S_DIV_BUSY = 2'd2;
  localparam logic [1:0] S_OUT_BUSY = 2'd3;

  // branch conditions
  localparam logic [2:0] B_NEXT       = 3'd0;
  localparam logic [2:0] B_ALWAYS     = 3'd1;
  localparam logic [2:0] B_NOT_DIV    = 3'd2;
  localparam logic [2:0] B_LEVEL_ZERO = 3'd3;
  localparam logic [2:0] B_DISPATCH   = 3'd4;

  // microprogram addresses
  localparam logic [IEE_UPC_W-1:0] U_WAIT     = 5'd0;
  localparam logic [IEE_UPC_W-1:0] U_DIGIT    = 5'd1;
  localparam logic [IEE_UPC_W-1:0] U_PUSH     = 5'd2;
  localparam logic [IEE_UPC_W-1:0] U_OVF      = 5'd3;
  localparam logic [IEE_UPC_W-1:0] U_AS_FAC   = 5'd4;
  localparam logic [IEE_UPC_W-1:0] U_AS_DIV   = 5'd5;
  localparam logic [IEE_UPC_W-1:0] U_AS_SUM   = 5'd6;
  localparam logic [IEE_UPC_W-1:0] U_MD_FAC   = 5'd7;
  localparam logic [IEE_UPC_W-1:0] U_MD_DIV   = 5'd8;
  localparam logic [IEE_UPC_W-1:0] U_MD_TERM  = 5'd9;
  localparam logic [IEE_UPC_W-1:0] U_CL_FAC   = 5'd10;
  localparam logic [IEE_UPC_W-1:0] U_CL_DIV   = 5'd11;
  localparam logic [IEE_UPC_W-1:0] U_CL_VAL   = 5'd12;
  localparam logic [IEE_UPC_W-1:0] U_CL_POP   = 5'd13;
  localparam logic [IEE_UPC_W-1:0] U_FN_FAC   = 5'd14;
  localparam logic [IEE_UPC_W-1:0] U_FN_DIV   = 5'd15;
  localparam logic [IEE_UPC_W-1:0] U_FN_VAL   = 5'd16;
  localparam logic [IEE_UPC_W-1:0] U_FN_POP   = 5'd17;
  localparam logic [IEE_UPC_W-1:0] U_EMIT     = 5'd18;

  typedef struct packed {
    logic [3:0]           act;
    logic [1:0]           stall;
    logic [2:0]           branch;
    logic [IEE_UPC_W-1:0] target;
  } iee_uword_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } iee_div_stat_t;

  function automatic iee_uword_t iee_ucode(input logic [IEE_UPC_W-1:0] addr);
    iee_uword_t w;
    w = '{act: A_WAIT, stall: S_NO_ITEM, branch: B_DISPATCH, target: U_WAIT};
    unique case (addr)
      U_WAIT:    w = '{act: A_WAIT,      stall: S_NO_ITEM,  branch: B_DISPATCH,
                       target: U_WAIT};
      U_DIGIT:   w = '{act: A_DIGIT,     stall: S_NONE,     branch: B_ALWAYS,
                       target: U_WAIT};
      U_PUSH:    w = '{act: A_PUSH,      stall: S_NONE,     branch: B_ALWAYS,
                       target: U_WAIT};
      U_OVF:     w = '{act: A_OVF,       stall: S_NONE,     branch: B_ALWAYS,
                       target: U_FN_FAC};
      U_AS_FAC:  w = '{act: A_FACTOR,    stall: S_NONE,     branch: B_NOT_DIV,
                       target: U_AS_SUM};
      U_AS_DIV:  w = '{act: A_DIVTAKE,   stall: S_DIV_BUSY, branch: B_NEXT,
                       target: U_WAIT};
      U_AS_SUM:  w = '{act: A_SUM,       stall: S_NONE,     branch: B_ALWAYS,
                       target: U_WAIT};
      U_MD_FAC:  w = '{act: A_FACTOR,    stall: S_NONE,     branch: B_NOT_DIV,
                       target: U_MD_TERM};
      U_MD_DIV:  w = '{act: A_DIVTAKE,   stall: S_DIV_BUSY, branch: B_NEXT,
                       target: U_WAIT};
      U_MD_TERM: w = '{act: A_TERM,      stall: S_NONE,     branch: B_ALWAYS,
                       target: U_WAIT};
      U_CL_FAC:  w = '{act: A_FACTOR,    stall: S_NONE,     branch: B_NOT_DIV,
                       target: U_CL_VAL};
      U_CL_DIV:  w = '{act: A_DIVTAKE,   stall: S_DIV_BUSY, branch: B_NEXT,
                       target: U_WAIT};
      U_CL_VAL:  w = '{act: A_VALUE,     stall: S_NONE,     branch: B_NEXT,
                       target: U_WAIT};
      U_CL_POP:  w = '{act: A_POP,       stall: S_NONE,     branch: B_ALWAYS,
                       target: U_WAIT};
      U_FN_FAC:  w = '{act: A_FACTOR,    stall: S_NONE,     branch: B_NOT_DIV,
                       target: U_FN_VAL};
      U_FN_DIV:  w = '{act: A_DIVTAKE,   stall: S_DIV_BUSY, branch: B_NEXT,
                       target: U_WAIT};
      U_FN_VAL:  w = '{act: A_VALUE_FIN, stall: S_NONE,     branch: B_LEVEL_ZERO,
                       target: U_EMIT};
      U_FN_POP:  w = '{act: A_POP,       stall: S_NONE,     branch: B_ALWAYS,
                       target: U_FN_FAC};
      U_EMIT:    w = '{act: A_EMIT,      stall: S_OUT_BUSY, branch: B_ALWAYS,
                       target: U_WAIT};
      default:   w = '{act: A_WAIT,      stall: S_NO_ITEM,  branch: B_DISPATCH,
                       target: U_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [IEE_UPC_W-1:0] iee_dispatch(
    input logic [7:0] ch,
    input logic [1:0] phase,
    input logic       open_full,
    input logic       level_nz
  );
    logic [IEE_UPC_W-1:0] a;
    a = U_FN_FAC;
    if (ch >= IEE_CH_0 && ch <= IEE_CH_9) begin
      a = (phase == IEE_PH_CLOSED) ? U_FN_FAC : U_DIGIT;
    end else if (ch == IEE_CH_ADD || ch == IEE_CH_SUB) begin
      a = U_AS_FAC;
    end else if (ch == IEE_CH_MUL || ch == IEE_CH_DIV) begin
      a = U_MD_FAC;
    end else if (ch == IEE_CH_OPEN) begin
      if (phase != IEE_PH_START) a = U_FN_FAC;
      else if (open_full)         a = U_OVF;
      else                        a = U_PUSH;
    end else if (ch == IEE_CH_CLOSE && level_nz) begin
      a = U_CL_FAC;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/iee_char_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iee_char_if
// Input channel: one character per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/iee_result_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iee_result_if
// Result channel: expression value and status per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iee_result_if;
  import iee_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [IEE_VALUE_W-1:0] value;
  logic [1:0]                    status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/iee_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iee_div
// Signed divider, truncating toward zero. Restoring, one quotient bit per
// cycle on magnitudes; a zero divisor finishes at once with quotient zero.
// ----------------------------------------------------------------------------
module iee_div #(
  parameter int DATA_WIDTH = iee_pkg::IEE_DATA_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DATA_WIDTH-1:0]   dividend,
  input  wire logic [DATA_WIDTH-1:0]   divisor,
  output logic [DATA_WIDTH-1:0]        quotient,
  output iee_pkg::iee_div_stat_t       stat
);
  import iee_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quot;
  logic [DATA_WIDTH-1:0] den;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  zero;

  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic [DATA_WIDTH:0]   trial;

  assign a_mag = dividend[DATA_WIDTH-1] ? DATA_WIDTH'(0) - dividend : dividend;
  assign b_mag = divisor[DATA_WIDTH-1]  ? DATA_WIDTH'(0) - divisor  : divisor;
  assign trial = {rem, quot[DATA_WIDTH-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zero <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= '0;
      den  <= b_mag;
      neg  <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      if (b_mag == '0) begin
        quot <= '0;
        zero <= 1'b1;
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        quot <= a_mag;
        zero <= 1'b0;
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_WIDTH);
      end
    end else if (busy) begin
      if (!trial[DATA_WIDTH]) begin
        rem <= trial[DATA_WIDTH-1:0];
      end else begin
        rem <= {rem[DATA_WIDTH-2:0], quot[DATA_WIDTH-1]};
      end
      quot <= {quot[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  assign quotient  = neg ? DATA_WIDTH'(0) - quot : quot;
  assign stat.busy = busy;
  assign stat.zero = zero;

endmodule
`default_nettype wire

// ----- hw/rtl/infix_expression_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Streaming evaluator of integer infix expressions, one character per item.
// ----------------------------------------------------------------------------
// Feed the expression one ASCII character per item: decimal numbers, + - * /
// with the usual precedence, and parentheses nested up to STACK_DEPTH deep.
// Any other character, a digit after ')', '(' after a digit or ')', or ')'
// with no open '(', ends the expression and produces one result item (value
// wrapping on DATA_WIDTH bits, status 0 ok, 1 division by zero, 2 nesting
// overflow or unbalanced); the block then starts over. A small microprogram
// drives the datapath, one routine per item; a terminator also closes every
// still-open '(' and waits for the previous result to be taken, and a
// pending division waits for the iterative divider to complete it. The
// finished result waits in an output register while the next expression is
// already being taken in.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::IEE_STACK_DEPTH,
  parameter int DATA_WIDTH  = iee_pkg::IEE_DATA_WIDTH
) (
  input wire logic     clk,
  input wire logic     rst,
  iee_char_if.sink     chars,
  iee_result_if.source results
);
  import iee_pkg::*;

  localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FRAME_W = 2 * DATA_WIDTH + 3;

  logic [IEE_UPC_W-1:0] upc;
  logic [IEE_UPC_W-1:0] upc_next;
  iee_uword_t           uw;
  logic                 stall;
  logic                 fire;

  logic [DATA_WIDTH-1:0] sum;
  logic                  sign;
  logic [DATA_WIDTH-1:0] term;
  logic [1:0]            mode;
  logic [DATA_WIDTH-1:0] acc;
  logic [1:0]            phase;
  logic [LVL_W-1:0]      level;
  logic [1:0]            err;
  logic [7:0]            ch;
  logic [DATA_WIDTH-1:0] fac;
  logic [DATA_WIDTH-1:0] vreg;

  logic [FRAME_W-1:0]    stack_mem [STACK_DEPTH];
  logic [FRAME_W-1:0]    frame;

  logic                  out_valid;
  logic [IEE_VALUE_W-1:0] out_value;
  logic [1:0]            out_status;

  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] lvl_val;
  logic [DATA_WIDTH-1:0] digit_acc;
  logic [LVL_W-1:0]      lvl_m1;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_q;
  iee_div_stat_t         div_stat;

  assign uw = iee_ucode(upc);

  always_comb begin
    unique case (uw.stall)
      S_NO_ITEM:  stall = !chars.valid;
      S_DIV_BUSY: stall = div_stat.busy;
      S_OUT_BUSY: stall = out_valid && !results.ready;
      default:    stall = 1'b0;
    endcase
  end

  assign fire        = !stall;
  assign chars.ready = (uw.stall == S_NO_ITEM);

  always_comb begin
    upc_next = upc;
    if (fire) begin
      unique case (uw.branch)
        B_ALWAYS:     upc_next = uw.target;
        B_NOT_DIV:    upc_next = (mode != IEE_MODE_DIV) ? uw.target : upc + IEE_UPC_W'(1);
        B_LEVEL_ZERO: upc_next = (level == '0) ? uw.target : upc + IEE_UPC_W'(1);
        B_DISPATCH:   upc_next = iee_dispatch(chars.ch, phase,
                                              level >= LVL_W'(STACK_DEPTH),
                                              level != '0);
        default:      upc_next = upc + IEE_UPC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  assign prod      = term * acc;
  assign lvl_val   = sign ? sum - fac : sum + fac;
  assign digit_acc = (acc << 3) + (acc << 1) + DATA_WIDTH'(ch[3:0]);
  assign lvl_m1    = level - LVL_W'(1);
  assign div_start = fire && (uw.act == A_FACTOR) && (mode == IEE_MODE_DIV);

  iee_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (term),
    .divisor  (acc),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (fire && uw.act == A_PUSH) begin
      stack_mem[level[IDX_W-1:0]] <= {sign, mode, term, sum};
    end
    if (fire && (uw.act == A_VALUE || uw.act == A_VALUE_FIN)) begin
      frame <= stack_mem[lvl_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sign  <= 1'b0;
      term  <= '0;
      mode  <= IEE_MODE_NONE;
      acc   <= '0;
      phase <= IEE_PH_START;
      level <= '0;
      err   <= IEE_ST_OK;
    end else if (fire) begin
      unique case (uw.act)
        A_WAIT: begin
          if (chars.valid) ch <= chars.ch;
        end
        A_DIGIT: begin
          acc   <= digit_acc;
          phase <= IEE_PH_NUMBER;
        end
        A_PUSH: begin
          level <= level + LVL_W'(1);
          sum   <= '0;
          sign  <= 1'b0;
          term  <= '0;
          mode  <= IEE_MODE_NONE;
          acc   <= '0;
          phase <= IEE_PH_START;
        end
        A_OVF: begin
          if (err == IEE_ST_OK) err <= IEE_ST_NEST;
        end
        A_FACTOR: begin
          fac <= (mode == IEE_MODE_MUL) ? prod : acc;
        end
        A_DIVTAKE: begin
          fac <= div_q;
          if (div_stat.zero && err == IEE_ST_OK) err <= IEE_ST_DIV_ZERO;
        end
        A_SUM: begin
          sum   <= lvl_val;
          sign  <= (ch == IEE_CH_SUB);
          term  <= '0;
          mode  <= IEE_MODE_NONE;
          acc   <= '0;
          phase <= IEE_PH_START;
        end
        A_TERM: begin
          term  <= fac;
          mode  <= (ch == IEE_CH_MUL) ? IEE_MODE_MUL : IEE_MODE_DIV;
          acc   <= '0;
          phase <= IEE_PH_START;
        end
        A_VALUE: begin
          vreg <= lvl_val;
        end
        A_VALUE_FIN: begin
          vreg <= lvl_val;
          if (level != '0 && err == IEE_ST_OK) err <= IEE_ST_NEST;
        end
        A_POP: begin
          sum   <= frame[DATA_WIDTH-1:0];
          term  <= frame[2*DATA_WIDTH-1:DATA_WIDTH];
          mode  <= frame[2*DATA_WIDTH+1:2*DATA_WIDTH];
          sign  <= frame[2*DATA_WIDTH+2];
          acc   <= vreg;
          phase <= IEE_PH_CLOSED;
          level <= lvl_m1;
        end
        A_EMIT: begin
          sum   <= '0;
          sign  <= 1'b0;
          term  <= '0;
          mode  <= IEE_MODE_NONE;
          acc   <= '0;
          phase <= IEE_PH_START;
          level <= '0;
          err   <= IEE_ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && uw.act == A_EMIT) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && uw.act == A_EMIT) begin
      out_value  <= IEE_VALUE_W'(vreg);
      out_status <= err;
    end
  end

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("nesting level beyond stack depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (fire && uw.act == A_POP) |-> level != '0)
    else $error("frame pop with empty stack");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && uw.act == A_EMIT) |=> (level == '0 && err == IEE_ST_OK && results.valid))
    else $error("result emitted without clearing state");

endmodule
`default_nettype wire

// ----- tb/sv/infix_expression_evaluator_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator_test
// Self-checking testbench of the streaming infix expression evaluator.
// ----------------------------------------------------------------------------
// Characters go in through the char channel in bursts with random gaps, and
// the result channel stalls on a pattern that cycles through always ready,
// coin toss, long stalls and rare stalls. A short table of expressions is
// sent first: the empty expression, division by zero, unbalanced '(', ')'
// with nothing open, a digit after ')', '(' after a digit, precedence, and the
// character codes 0x00 and 0xFF as terminators. Random expressions follow:
// mostly well-formed nested expressions with random numbers, some nested past
// the frame stack depth, the most negative value divided by -1, and plain
// character noise. A testbench evaluator tracks every accepted character and
// predicts each result's value and status, but fixed table rows use their own.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_CHARS = 1650;
  localparam int SETTLE       = 160;
  localparam int DIR_ROWS     = 9;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  iee_char_if   chars();
  iee_result_if results();

  infix_expression_evaluator uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed expressions; a tail of -1 means no extra raw byte
  string      row_text   [DIR_ROWS] = '{"x", "9/0;", "(1+2;", "4)", "(2)3", "5(",
                                        "7-8*2/3", "", "2*(3-9)."};
  int         row_tail   [DIR_ROWS] = '{-1, -1, -1, -1, -1, -1, 255, 0, -1};
  bit         row_fixed  [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 0};
  int         row_value  [DIR_ROWS] = '{0, 0, 3, 4, 2, 5, 2, 0, 0};
  logic [1:0] row_status [DIR_ROWS] = '{IEE_ST_OK, IEE_ST_DIV_ZERO, IEE_ST_NEST,
                                        IEE_ST_OK, IEE_ST_OK, IEE_ST_OK,
                                        IEE_ST_OK, IEE_ST_OK, IEE_ST_OK};

  // evaluator state
  logic [31:0] ex_sum, ex_term, ex_num;
  logic        ex_neg;
  logic [1:0]  ex_mode, ex_phase, ex_err;
  int          ex_depth;
  logic [31:0] fr_sum  [IEE_STACK_DEPTH];
  logic        fr_neg  [IEE_STACK_DEPTH];
  logic [31:0] fr_term [IEE_STACK_DEPTH];
  logic [1:0]  fr_mode [IEE_STACK_DEPTH];

  outcome_t    pending_results[$];
  logic [7:0]  expr_chars[$];
  string       operand_syms = "0123456789+-*/()";
  string       operators    = "+-*/";

  bit          row_typed;
  outcome_t    row_outcome;
  bit          emitted;
  outcome_t    predicted;
  outcome_t    want;

  int cycles;
  int sent;
  int burst_left;
  int failures;
  int expressions;
  int div_zero_seen;
  int nest_seen;
  int results_seen;

  task automatic clear_level();
    ex_sum   = '0;
    ex_neg   = 1'b0;
    ex_term  = '0;
    ex_mode  = IEE_MODE_NONE;
    ex_num   = '0;
    ex_phase = IEE_PH_START;
  endtask

  task automatic reset_evaluator();
    clear_level();
    ex_depth = 0;
    ex_err   = IEE_ST_OK;
  endtask

  function automatic logic [31:0] quotient_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == '0) begin
      if (ex_err == IEE_ST_OK) ex_err = IEE_ST_DIV_ZERO;
      return '0;
    end
    q = ma / mb;
    if (a[31] != b[31]) q = -q;
    return q;
  endfunction

  function automatic logic [31:0] factor_value();
    if (ex_mode == IEE_MODE_MUL) return ex_term * ex_num;
    if (ex_mode == IEE_MODE_DIV) return quotient_of(ex_term, ex_num);
    return ex_num;
  endfunction

  function automatic logic [31:0] level_value();
    logic [31:0] t;
    t = factor_value();
    return ex_neg ? ex_sum - t : ex_sum + t;
  endfunction

  task automatic pop_frame(input logic [31:0] v);
    int i;
    i = ex_depth - 1;
    ex_sum   = fr_sum[i];
    ex_neg   = fr_neg[i];
    ex_term  = fr_term[i];
    ex_mode  = fr_mode[i];
    ex_num   = v;
    ex_phase = IEE_PH_CLOSED;
    ex_depth--;
  endtask

  task automatic finish_expression(output outcome_t r);
    logic [31:0] v;
    v = level_value();
    if (ex_depth > 0 && ex_err == IEE_ST_OK) ex_err = IEE_ST_NEST;
    while (ex_depth > 0) begin
      pop_frame(v);
      v = level_value();
    end
    r.value  = v;
    r.status = ex_err;
    reset_evaluator();
  endtask

  task automatic evaluate_char(input logic [7:0] c, output bit done, output outcome_t r);
    logic [31:0] v;
    done = 1'b0;
    r    = '0;
    if (c >= IEE_CH_0 && c <= IEE_CH_9) begin
      if (ex_phase == IEE_PH_CLOSED) begin
        finish_expression(r);
        done = 1'b1;
      end else begin
        ex_num   = ex_num * 32'd10 + 32'(c - IEE_CH_0);
        ex_phase = IEE_PH_NUMBER;
      end
    end else if (c == IEE_CH_ADD || c == IEE_CH_SUB) begin
      v        = level_value();
      ex_sum   = v;
      ex_neg   = (c == IEE_CH_SUB);
      ex_term  = '0;
      ex_mode  = IEE_MODE_NONE;
      ex_num   = '0;
      ex_phase = IEE_PH_START;
    end else if (c == IEE_CH_MUL || c == IEE_CH_DIV) begin
      v        = factor_value();
      ex_term  = v;
      ex_mode  = (c == IEE_CH_MUL) ? IEE_MODE_MUL : IEE_MODE_DIV;
      ex_num   = '0;
      ex_phase = IEE_PH_START;
    end else if (c == IEE_CH_OPEN && ex_phase == IEE_PH_START &&
                 ex_depth < IEE_STACK_DEPTH) begin
      fr_sum[ex_depth]  = ex_sum;
      fr_neg[ex_depth]  = ex_neg;
      fr_term[ex_depth] = ex_term;
      fr_mode[ex_depth] = ex_mode;
      ex_depth++;
      clear_level();
    end else if (c == IEE_CH_CLOSE && ex_depth > 0) begin
      pop_frame(level_value());
    end else begin
      if (c == IEE_CH_OPEN && ex_phase == IEE_PH_START && ex_err == IEE_ST_OK)
        ex_err = IEE_ST_NEST;
      finish_expression(r);
      done = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_evaluator();
    end else begin
      if (chars.valid && chars.ready === 1'b1) begin
        evaluate_char(chars.ch, emitted, predicted);
        if (emitted) begin
          if (row_typed) predicted = row_outcome;
          pending_results.insert(pending_results.size(), predicted);
          expressions++;
          if (predicted.status == IEE_ST_DIV_ZERO) div_zero_seen++;
          if (predicted.status == IEE_ST_NEST) nest_seen++;
        end
      end
      if (results.valid === 1'b1 && results.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: value %0d status %0d",
                     results.value, results.status);
        end else begin
          want = pending_results.pop_front();
          if (results.value !== want.value || results.status !== want.status) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       $signed(want.value), want.status, results.value, results.status);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    case (cycles[9:8])
      2'd0:    results.ready <= 1'b1;
      2'd1:    results.ready <= 1'($urandom_range(0, 1));
      2'd2:    results.ready <= (cycles % 41) < 9;
      default: results.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycles, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        chars.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    chars.valid <= 1'b1;
    chars.ch    <= c;
    do @(posedge clk); while (chars.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_expression();
    while (expr_chars.size() != 0) send_char(expr_chars.pop_front());
  endtask

  task automatic drain_results();
    chars.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic queue_char(input logic [7:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic bit is_operand_char(logic [7:0] c);
    return (c >= IEE_CH_0 && c <= IEE_CH_9) || c == IEE_CH_ADD || c == IEE_CH_SUB ||
           c == IEE_CH_MUL || c == IEE_CH_DIV || c == IEE_CH_OPEN || c == IEE_CH_CLOSE;
  endfunction

  function automatic logic [7:0] pick_terminator(bit allow_close);
    logic [7:0] c;
    if (allow_close && $urandom_range(0, 4) == 0) return IEE_CH_CLOSE;
    do c = 8'($urandom_range(0, 255)); while (is_operand_char(c));
    return c;
  endfunction

  task automatic add_number();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 5)       n = 0;
    else if (r < 75) n = 1;
    else if (r < 90) n = $urandom_range(2, 3);
    else             n = $urandom_range(4, 12);
    repeat (n) queue_char(IEE_CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic gen_expression();
    int kind, nfac, open, k, n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      nfac = $urandom_range(1, 8);
      open = 0;
      for (int i = 0; i < nfac; i++) begin
        if (i > 0) queue_char(operators[$urandom_range(0, 3)]);
        while (open < IEE_STACK_DEPTH - 1 && $urandom_range(0, 3) == 0) begin
          queue_char(IEE_CH_OPEN);
          open++;
        end
        add_number();
        if (open > 0 && $urandom_range(0, 2) == 0) begin
          queue_char(IEE_CH_CLOSE);
          open--;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        repeat (open) queue_char(IEE_CH_CLOSE);
        open = 0;
      end
      queue_char(pick_terminator(open == 0));
    end else if (kind < 80) begin
      k = $urandom_range(IEE_STACK_DEPTH - 2, IEE_STACK_DEPTH + 2);
      repeat (k) queue_char(IEE_CH_OPEN);
      add_number();
      repeat ($urandom_range(0, k)) queue_char(IEE_CH_CLOSE);
      queue_char(pick_terminator(1'b0));
    end else if (kind < 85) begin
      case ($urandom_range(0, 2))
        0:       push_text("2147483648/(0-1)");
        1:       push_text("(0-2147483648)/(0-1)*1");
        default: push_text("2147483647+1");
      endcase
      queue_char(pick_terminator(1'b0));
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 9) < 6)
          queue_char(operand_syms[$urandom_range(0, 15)]);
        else
          queue_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int stop_at;
    bit mid_pause;
    rst           = 1'b1;
    chars.valid   = 1'b0;
    chars.ch      = '0;
    row_typed     = 1'b0;
    row_outcome   = '0;
    sent          = 0;
    burst_left    = 0;
    failures      = 0;
    expressions   = 0;
    div_zero_seen = 0;
    nest_seen     = 0;
    results_seen  = 0;
    mid_pause     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_text(row_text[r]);
      if (row_tail[r] >= 0) queue_char(8'(row_tail[r]));
      row_typed          = row_fixed[r];
      row_outcome.value  = 32'(row_value[r]);
      row_outcome.status = row_status[r];
      send_expression();
    end
    row_typed = 1'b0;
    drain_results();

    stop_at = sent + RANDOM_CHARS;
    while (sent < stop_at) begin
      gen_expression();
      send_expression();
      if (!mid_pause && sent >= stop_at - RANDOM_CHARS / 2) begin
        drain_results();
        mid_pause = 1'b1;
      end
    end
    queue_char(pick_terminator(1'b0));
    send_expression();

    drain_results();
    repeat (SETTLE) @(negedge clk);

    $display("%0d characters sent, %0d expressions, %0d results checked in %0d cycles",
             sent, expressions, results_seen, cycles);
    $display("%0d expressions with division by zero, %0d with nesting errors",
             div_zero_seen, nest_seen);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/iee_pkg.sv
hw/rtl/iee_char_if.sv
hw/rtl/iee_result_if.sv
hw/rtl/iee_div.sv
hw/rtl/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_test.sv
